// ===== src/fssu_pkg.sv =====
// Package: shared constants, types and command structs for the Sobel/stretch unit.
package fssu_pkg;
   localparam int DEF_MAX_WIDTH  = 1024;
   localparam int DEF_MAX_HEIGHT = 1024;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 11;
   localparam logic [CSR_IDX_W-1:0] CSR_EDGE_MODE    = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;
   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_FETCH = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_LOAD, ST_RD0, ST_RD1, ST_RD2, ST_RD3, ST_RD4, ST_SUM,
      ST_DIV, ST_OUT
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic       load_wr;    // write gray, advance load index
      logic [1:0] rd_row;     // 0: y-1, 1: y, 2: y+1
      logic [1:0] rd_col;     // 0: x-1, 1: x, 2: x+1
      logic       rd_en;
      logic [3:0] cap_slot;   // window slot captured from previous read
      logic       cap_en;
      logic       sum_en;
      logic       div_start;
      logic       out_load;
      logic       advance;    // step fetch index or restart
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic full;
      logic done_fetch;
      logic border;
      logic edge_sel;
      logic div_busy;
   } sts_type;
endpackage

// ===== src/frame_sobel_or_contrast_stretch_unit.sv =====
// Top level: Sobel edge magnitude or min-max contrast stretch over a stored gray frame.
// Each load is accepted in idle, where gray is written into the frame store unless it
// is full, and then passes through a load state back to idle. A border fetch goes
// straight to the output state; an interior Sobel fetch first makes nine single-port
// reads of the 3x3 window from the frame store; a stretch fetch then also runs the
// bit-serial divider. One result is held in an output register; a fetch waits while a
// previous result is still untaken, a load does not. No clearing pass after reset: the
// store is read only after a full frame is written.
module frame_sobel_or_contrast_stretch_unit #(
   parameter int MAX_WIDTH  = fssu_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = fssu_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [fssu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fssu_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic                            req_action,
   input  logic [7:0]                      req_blue,
   input  logic [7:0]                      req_green,
   input  logic [7:0]                      req_red,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_pixel_out,
   output logic                            rsp_frame_last
);
   import fssu_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequence each transaction
   fssu_ctrl u_ctrl (
      .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
      .req_action(req_action), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .sts(sts), .cmd(cmd)
   );

   // hold frame, window and result
   fssu_datapath #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
      .clock(clock), .reset(reset), .csr_write(csr_write), .csr_index(csr_index),
      .csr_data(csr_data), .blue(req_blue), .green(req_green), .red(req_red),
      .cmd(cmd), .sts(sts), .pixel_out(rsp_pixel_out), .frame_last(rsp_frame_last)
   );
endmodule

// ===== src/fssu_div.sv =====
// Restoring divider: 16-bit dividend by 8-bit divisor, one quotient bit per cycle.
module fssu_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [15:0] dividend,
   input  logic [7:0]  divisor,
   output logic        busy,
   output logic [15:0] quotient
);
   logic [4:0]  cnt_ff, cnt_in;
   logic [8:0]  rem_ff, rem_in;
   logic [15:0] q_ff, q_in;
   logic [7:0]  d_ff, d_in;
   logic [8:0]  trial;

   always_comb begin
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      q_in   = q_ff;
      d_in   = d_ff;
      trial  = {rem_ff[7:0], q_ff[15]};
      if (start) begin
         cnt_in = 5'd16;
         rem_in = '0;
         q_in   = dividend;
         d_in   = divisor;
      end else if (cnt_ff != 5'd0) begin
         cnt_in = cnt_ff - 5'd1;
         if (trial >= {1'b0, d_ff}) begin
            rem_in = trial - {1'b0, d_ff};
            q_in   = {q_ff[14:0], 1'b1};
         end else begin
            rem_in = trial;
            q_in   = {q_ff[14:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      d_ff   <= d_in;
   end

   assign busy     = (cnt_ff != 5'd0);
   assign quotient = q_ff;
endmodule

// ===== src/fssu_datapath.sv =====
// Datapath: configuration, frame store, window registers, Sobel and stretch arithmetic.
module fssu_datapath #(
   parameter int MAX_WIDTH  = fssu_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT = fssu_pkg::DEF_MAX_HEIGHT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [fssu_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [fssu_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic [7:0]                      blue,
   input  logic [7:0]                      green,
   input  logic [7:0]                      red,
   input  fssu_pkg::cmd_type               cmd,
   output fssu_pkg::sts_type               sts,
   output logic [7:0]                      pixel_out,
   output logic                            frame_last
);
   import fssu_pkg::*;

   localparam int XW = $clog2(MAX_WIDTH + 1);
   localparam int YW = $clog2(MAX_HEIGHT + 1);
   localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
   localparam int AW = $clog2(DEPTH);
   localparam int TW = $clog2(DEPTH + 1);

   logic        mode_ff;
   logic [10:0] fw_ff, fh_ff;
   logic        restart;

   // saturate sizes
   logic [XW-1:0] w_use;
   logic [YW-1:0] h_use;
   always_comb begin
      if (fw_ff < 11'd3) w_use = XW'(3);
      else if ({21'd0, fw_ff} > 32'(MAX_WIDTH)) w_use = XW'(MAX_WIDTH);
      else w_use = XW'(fw_ff);
      if (fh_ff < 11'd3) h_use = YW'(3);
      else if ({21'd0, fh_ff} > 32'(MAX_HEIGHT)) h_use = YW'(MAX_HEIGHT);
      else h_use = YW'(fh_ff);
   end

   // total pixels, registered product
   logic [TW-1:0] total_ff;
   always_ff @(posedge clock) begin
      total_ff <= TW'(w_use * h_use);
   end

   logic [TW-1:0] load_idx_ff;
   logic [XW-1:0] fx_ff;
   logic [YW-1:0] fy_ff;
   logic [TW-1:0] fidx_ff;
   logic [TW-1:0] row_base_ff;
   logic [7:0]    min_ff, max_ff;
   logic          last_pix;

   assign last_pix = (fidx_ff == total_ff - TW'(1));
   assign restart  = (csr_write && (csr_index == CSR_FRAME_WIDTH ||
                      csr_index == CSR_FRAME_HEIGHT)) || (cmd.advance && last_pix);

   // gray conversion: multiply by 683/2048, exact floor of sum/3 up to 765
   logic [9:0]  rgb_sum;
   logic [19:0] gray_prod;
   logic [7:0]  gray;
   assign rgb_sum   = 10'(blue) + 10'(green) + 10'(red);
   assign gray_prod = 20'(rgb_sum) * 20'd683;
   assign gray      = gray_prod[18:11];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= 1'b1;
         fw_ff   <= 11'd640;
         fh_ff   <= 11'd480;
      end else if (csr_write) begin
         case (csr_index)
            CSR_EDGE_MODE:    mode_ff <= csr_data[0];
            CSR_FRAME_WIDTH:  fw_ff   <= csr_data;
            CSR_FRAME_HEIGHT: fh_ff   <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset || restart) begin
         load_idx_ff <= '0;
         fx_ff       <= '0;
         fy_ff       <= '0;
         fidx_ff     <= '0;
         row_base_ff <= '0;
         min_ff      <= 8'd255;
         max_ff      <= 8'd0;
      end else begin
         if (cmd.load_wr) begin
            load_idx_ff <= load_idx_ff + TW'(1);
            if (gray < min_ff) min_ff <= gray;
            if (gray > max_ff) max_ff <= gray;
         end
         if (cmd.advance) begin
            fidx_ff <= fidx_ff + TW'(1);
            if (fx_ff == w_use - XW'(1)) begin
               fx_ff       <= '0;
               fy_ff       <= fy_ff + YW'(1);
               row_base_ff <= row_base_ff + TW'(w_use);
            end else begin
               fx_ff <= fx_ff + XW'(1);
            end
         end
      end
   end

   // frame store
   logic [7:0]    mem [DEPTH];
   logic [7:0]    rd_ff;
   logic [TW-1:0] rd_addr;
   always_comb begin
      rd_addr = row_base_ff + TW'(fx_ff);
      case (cmd.rd_row)
         2'd0:    rd_addr = rd_addr - TW'(w_use);
         2'd2:    rd_addr = rd_addr + TW'(w_use);
         default: ;
      endcase
      case (cmd.rd_col)
         2'd0:    rd_addr = rd_addr - TW'(1);
         2'd2:    rd_addr = rd_addr + TW'(1);
         default: ;
      endcase
   end
   always_ff @(posedge clock) begin
      if (cmd.load_wr) mem[AW'(load_idx_ff)] <= gray;
      if (cmd.rd_en)   rd_ff <= mem[AW'(rd_addr)];
   end

   // 3x3 window, slot = row*3+col
   logic [7:0] win_ff [9];
   always_ff @(posedge clock) begin
      if (cmd.cap_en) win_ff[cmd.cap_slot] <= rd_ff;
   end

   logic signed [11:0] gx, gy;
   logic [11:0]        ax, ay;
   logic [12:0]        mag;
   logic [7:0]         sob_ff;
   logic [15:0]        num_ff;
   logic [7:0]         den_ff;
   logic               zero_ff;
   logic [7:0]         gc;
   assign gc = win_ff[4];
   always_comb begin
      gx = 12'(win_ff[0]) + 12'(win_ff[3]) * 12'sd2 + 12'(win_ff[6])
         - 12'(win_ff[2]) - 12'(win_ff[5]) * 12'sd2 - 12'(win_ff[8]);
      gy = 12'(win_ff[0]) + 12'(win_ff[1]) * 12'sd2 + 12'(win_ff[2])
         - 12'(win_ff[6]) - 12'(win_ff[7]) * 12'sd2 - 12'(win_ff[8]);
      ax = gx[11] ? 12'(-gx) : 12'(gx);
      ay = gy[11] ? 12'(-gy) : 12'(gy);
      mag = 13'(ax) + 13'(ay);
   end
   always_ff @(posedge clock) begin
      if (cmd.sum_en) begin
         sob_ff  <= (mag > 13'd255) ? 8'd255 : mag[7:0];
         num_ff  <= 16'((gc - min_ff) * 16'd255);
         den_ff  <= max_ff - min_ff;
         zero_ff <= (max_ff <= min_ff) || (gc < min_ff);
      end
   end

   logic        div_busy;
   logic [15:0] quo;
   fssu_div u_div (
      .clock(clock), .reset(reset), .start(cmd.div_start), .dividend(num_ff),
      .divisor(den_ff), .busy(div_busy), .quotient(quo)
   );

   logic border;
   assign border = (fx_ff == '0) || (fy_ff == '0) || (fx_ff == w_use - XW'(1)) ||
                   (fy_ff == h_use - YW'(1));

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         frame_last <= last_pix;
         if (border) pixel_out <= 8'd0;
         else if (mode_ff) pixel_out <= sob_ff;
         else if (zero_ff) pixel_out <= 8'd0;
         else pixel_out <= (quo > 16'd255) ? 8'd255 : quo[7:0];
      end
   end

   assign sts.full       = (load_idx_ff >= total_ff);
   assign sts.done_fetch = (fidx_ff >= total_ff);
   assign sts.border     = border;
   assign sts.edge_sel   = mode_ff;
   assign sts.div_busy   = div_busy;
endmodule

// ===== src/fssu_ctrl.sv =====
// Controller: sequences loads, window reads, arithmetic and result handoff.
module fssu_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_action,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   input  fssu_pkg::sts_type sts,
   output fssu_pkg::cmd_type cmd
);
   import fssu_pkg::*;

   state_type  state_ff, state_in;
   logic       rv_ff, rv_in;
   logic [3:0] step_ff, step_in;
   logic       take;

   assign take = req_valid && req_ready;
   assign req_ready = (state_ff == ST_IDLE) && !(rv_ff && req_action == ACTION_FETCH);

   // read step k in 0..8 reads slot k; capture of slot k-1 on same cycle
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      case (state_ff)
         ST_IDLE: begin
            if (take) begin
               if (req_action == ACTION_LOAD) state_in = ST_LOAD;
               else if (sts.full && !sts.done_fetch) begin
                  if (sts.border) state_in = ST_OUT;
                  else begin
                     state_in = ST_RD0;
                     step_in  = 4'd0;
                  end
               end
            end
         end
         ST_LOAD: state_in = ST_IDLE;
         ST_RD0: begin
            step_in = step_ff + 4'd1;
            if (step_ff == 4'd9) state_in = ST_SUM;
         end
         ST_SUM: state_in = sts.edge_sel ? ST_OUT : ST_DIV;
         ST_DIV: if (!sts.div_busy && step_ff == 4'd0) state_in = ST_OUT;
                 else step_in = 4'd0;
         ST_OUT:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.load_wr = (state_ff == ST_IDLE) && take && req_action == ACTION_LOAD && !sts.full;
      case (state_ff)
         ST_RD0: begin
            cmd.rd_en    = (step_ff < 4'd9);
            if (step_ff >= 4'd6) begin
               cmd.rd_row = 2'd2;
               cmd.rd_col = 2'(step_ff - 4'd6);
            end else if (step_ff >= 4'd3) begin
               cmd.rd_row = 2'd1;
               cmd.rd_col = 2'(step_ff - 4'd3);
            end else begin
               cmd.rd_row = 2'd0;
               cmd.rd_col = 2'(step_ff);
            end
            cmd.cap_en   = (step_ff != 4'd0);
            cmd.cap_slot = step_ff - 4'd1;
         end
         ST_SUM: cmd.sum_en = 1'b1;
         ST_DIV: cmd.div_start = (step_ff != 4'd0);
         ST_OUT: begin
            cmd.out_load = 1'b1;
            cmd.advance  = 1'b1;
         end
         default: ;
      endcase
   end

   always_comb begin
      rv_in = rv_ff;
      if (rsp_valid && rsp_ready) rv_in = 1'b0;
      if (state_ff == ST_OUT) rv_in = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
         step_ff  <= (state_ff == ST_SUM) ? 4'd1 : step_in;
      end
   end

   assign rsp_valid = rv_ff;
endmodule

// ===== src/fssu_checker.sv =====
// Checker: port-level assertions for the Sobel/stretch unit, with its bind.
module fssu_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_action,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_pixel_out,
   input logic       rsp_frame_last
);
   import fssu_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pixel_out)
      && $stable(rsp_frame_last)) else $error("result changed while stalled");
   a_no_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid) else $error("result valid after reset");
   a_load_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ACTION_LOAD && !rsp_valid |=> !rsp_valid)
      else $error("load produced a result");
   a_busy_after: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action == ACTION_LOAD |=> !req_ready)
      else $error("load accepted back to back");
endmodule

bind frame_sobel_or_contrast_stretch_unit fssu_checker u_chk (
   .clock(clock), .reset(reset), .req_valid(req_valid), .req_ready(req_ready),
   .req_action(req_action), .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
   .rsp_pixel_out(rsp_pixel_out), .rsp_frame_last(rsp_frame_last)
);
